FILE: sv/mono_framebuffer_draw_engine_macros.svh
// Assertion macros for the draw engine; they expect clk and arst_n in scope.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

`define MFB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define MFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mfb_pkg.sv
package mfb_pkg;

	localparam int SCREEN_COLS = 128;
	localparam int SCREEN_ROWS = 64;
	localparam int COL_W = $clog2(SCREEN_COLS);
	localparam int ROW_W = $clog2(SCREEN_ROWS);
	localparam int CW = 12;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [SCREEN_ROWS-1:0] colword_t;

	localparam coord_t COLS_C = coord_t'(SCREEN_COLS);
	localparam coord_t ROWS_C = coord_t'(SCREEN_ROWS);
	localparam coord_t ZERO_C = coord_t'(0);
	localparam coord_t ONE_C = coord_t'(1);
	localparam coord_t TWO_C = coord_t'(2);

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_HSPAN = 3'd1,
		OP_VSPAN = 3'd2,
		OP_LINE  = 3'd3,
		OP_RECT  = 3'd4,
		OP_FILL  = 3'd5,
		OP_READ  = 3'd6
	} opcode_t;

	localparam logic [1:0] REG_XOR_MODE = 2'd0;
	localparam logic [1:0] REG_ROTATE   = 2'd1;

	typedef enum logic {
		SEG_REGION = 1'b0,
		SEG_LINE   = 1'b1
	} seg_kind_t;

	// region: columns [a,b), rows [c,d); line: start (a,b), delta (c,d)
	typedef struct packed {
		seg_kind_t kind;
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
	} seg_t;

	typedef struct packed {
		logic active;
		logic hit;
		logic last;
		logic [COL_W-1:0] col;
		colword_t mask;
	} wop_t;

	function automatic seg_t region_seg(coord_t c0, coord_t c1, coord_t r0, coord_t r1);
		seg_t s;
		s.kind = SEG_REGION;
		s.a = c0;
		s.b = c1;
		s.c = r0;
		s.d = r1;
		return s;
	endfunction

	function automatic seg_t hspan_seg(coord_t x, coord_t y, coord_t w);
		if (w < ZERO_C)
			return region_seg(x + w, x, y, y + ONE_C);
		return region_seg(x, x + w, y, y + ONE_C);
	endfunction

	function automatic seg_t vspan_seg(coord_t x, coord_t y, coord_t h);
		if (h < ZERO_C)
			return region_seg(x, x + ONE_C, y + h + ONE_C, y + ONE_C);
		return region_seg(x, x + ONE_C, y, y + h);
	endfunction

	function automatic seg_t line_seg(coord_t x, coord_t y, coord_t x2, coord_t y2);
		coord_t dx;
		coord_t dy;
		seg_t s;
		dx = x2 - x;
		dy = y2 - y;
		if (dx == ZERO_C)
			return vspan_seg(x, y, dy);
		if (dy == ZERO_C)
			return hspan_seg(x, y, dx);
		s.kind = SEG_LINE;
		s.a = x;
		s.b = y;
		s.c = dx;
		s.d = dy;
		return s;
	endfunction

	function automatic logic [2:0] seg_count(opcode_t op);
		if (op == OP_RECT)
			return 3'd4;
		return 3'd1;
	endfunction

	function automatic seg_t cmd_seg(opcode_t op, logic rot, coord_t xp, coord_t yp,
		coord_t xa, coord_t ya, logic [1:0] k);
		coord_t t;
		seg_t s;
		t = ROWS_C - ONE_C - xp;
		s = region_seg(ZERO_C, ZERO_C, ZERO_C, ZERO_C);
		case (op)
			OP_HSPAN: s = hspan_seg(xp, yp, xa);
			OP_VSPAN: s = vspan_seg(xp, yp, ya);
			OP_LINE: begin
				if (rot)
					s = line_seg(yp, ROWS_C - xp, ya, ROWS_C - xa);
				else
					s = line_seg(xp, yp, xa, ya);
			end
			OP_RECT: begin
				if (rot) begin
					case (k)
						2'd0: s = hspan_seg(yp, t, ya);
						2'd1: s = hspan_seg(yp, t - xa + ONE_C, ya);
						2'd2: s = vspan_seg(yp, t - xa + TWO_C, xa - TWO_C);
						default: s = vspan_seg(yp + ya - ONE_C, t - xa + TWO_C, xa - TWO_C);
					endcase
				end else begin
					case (k)
						2'd0: s = hspan_seg(xp, yp, xa);
						2'd1: s = vspan_seg(xp, yp + ONE_C, ya - ONE_C);
						2'd2: s = hspan_seg(xp + ONE_C, yp + ya - ONE_C, xa - ONE_C);
						default: s = vspan_seg(xp + xa - ONE_C, yp + ONE_C, ya - TWO_C);
					endcase
				end
			end
			OP_FILL: begin
				if (rot)
					s = region_seg(yp, yp + ya, ROWS_C - xp - xa, ROWS_C - xp);
				else
					s = region_seg(xp, xp + xa, yp, yp + ya);
			end
			default: s = region_seg(ZERO_C, ZERO_C, ZERO_C, ZERO_C);
		endcase
		return s;
	endfunction

endpackage

FILE: sv/mfb_walker.sv
module mfb_walker import mfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  seg_t seg,
	input  logic take,
	output wop_t op
);

	logic      active_q;
	seg_kind_t kind_q;
	coord_t    cur_q;
	coord_t    hi_q;
	colword_t  mask_q;
	coord_t    x0_q;
	coord_t    y0_q;
	coord_t    i_q;
	coord_t    q_q;
	coord_t    rem_q;
	coord_t    dmaj_q;
	coord_t    dmin_q;
	logic      xmaj_q;
	logic      sx_q;
	logic      sy_q;

	coord_t   lo_c;
	coord_t   hi_c;
	colword_t rmask;
	coord_t   ax;
	coord_t   ay;
	coord_t   dxo;
	coord_t   dyo;
	coord_t   lcol;
	coord_t   lrow;
	coord_t   sum;

	always_comb begin
		lo_c = (seg.a < ZERO_C) ? ZERO_C : seg.a;
		hi_c = (seg.b > COLS_C) ? COLS_C : seg.b;
		for (int r = 0; r < SCREEN_ROWS; r++)
			rmask[r] = (coord_t'(r) >= seg.c) && (coord_t'(r) < seg.d);
		ax = (seg.c < ZERO_C) ? -seg.c : seg.c;
		ay = (seg.d < ZERO_C) ? -seg.d : seg.d;
	end

	always_comb begin
		if (xmaj_q) begin
			dxo = sx_q ? -i_q : i_q;
			dyo = sy_q ? -q_q : q_q;
		end else begin
			dxo = sx_q ? -q_q : q_q;
			dyo = sy_q ? -i_q : i_q;
		end
		lcol = x0_q + dxo;
		lrow = y0_q + dyo;
		sum = rem_q + dmin_q;
		op.active = active_q;
		if (kind_q == SEG_REGION) begin
			op.hit = 1'b1;
			op.last = (cur_q == hi_q - ONE_C);
			op.col = cur_q[COL_W-1:0];
			op.mask = mask_q;
		end else begin
			op.hit = (lcol >= ZERO_C) && (lcol < COLS_C) && (lrow >= ZERO_C) && (lrow < ROWS_C);
			op.last = (i_q == dmaj_q - ONE_C);
			op.col = lcol[COL_W-1:0];
			op.mask = colword_t'(1) << lrow[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start) begin
			if (seg.kind == SEG_REGION)
				active_q <= (lo_c < hi_c) && (|rmask);
			else
				active_q <= 1'b1;
		end else if (take && active_q && op.last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= seg.kind;
			cur_q <= lo_c;
			hi_q <= hi_c;
			mask_q <= rmask;
			x0_q <= seg.a;
			y0_q <= seg.b;
			xmaj_q <= ax > ay;
			dmaj_q <= (ax > ay) ? ax : ay;
			dmin_q <= (ax > ay) ? ay : ax;
			sx_q <= seg.c < ZERO_C;
			sy_q <= seg.d < ZERO_C;
			i_q <= ZERO_C;
			q_q <= ZERO_C;
			rem_q <= ZERO_C;
		end else if (take && active_q) begin
			cur_q <= cur_q + ONE_C;
			i_q <= i_q + ONE_C;
			if (sum >= dmaj_q) begin
				rem_q <= sum - dmaj_q;
				q_q <= q_q + ONE_C;
			end else begin
				rem_q <= sum;
			end
		end
	end

endmodule

FILE: sv/mono_framebuffer_draw_engine.sv
// channel  | handshake            | beat
// cmd      | cmd_valid/cmd_stall  | opcode, x_pos, y_pos, x_arg, y_arg
// res      | res_valid/res_stall  | column_bits, done_res
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// One command at a time. Every touched column is read, then written back, through
// the single column memory. Clear drops the per-column valid bits at once, no sweep.
// Reset: blank screen, xor_mode 0, rotate_view 1. The result beat holds until taken.
`include "mono_framebuffer_draw_engine_macros.svh"

module mono_framebuffer_draw_engine import mfb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [2:0]        opcode,
	input  logic signed [8:0] x_pos,
	input  logic signed [8:0] y_pos,
	input  logic signed [8:0] x_arg,
	input  logic signed [8:0] y_arg,
	output logic              res_valid,
	input  logic              res_stall,
	output colword_t          column_bits,
	output logic              done_res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [0:0]        cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SEG  = 6'b000010,
		S_WALK = 6'b000100,
		S_WR   = 6'b001000,
		S_RDC  = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t   state_q;
	opcode_t  op_q;
	coord_t   xp_q;
	coord_t   yp_q;
	coord_t   xa_q;
	coord_t   ya_q;
	logic [2:0] seg_k_q;
	logic     xor_q;
	logic     rot_q;
	logic [SCREEN_COLS-1:0] vld_q;
	logic [COL_W-1:0] col_q;
	colword_t mask_q;
	colword_t rdata_q;
	colword_t bits_q;
	logic     done_q;
	colword_t mem [SCREEN_COLS];

	logic       start;
	logic       take;
	seg_t       seg;
	wop_t       wop;
	logic [COL_W-1:0] rd_addr;
	colword_t   old_word;
	colword_t   wdata;
	logic       rd_in_range;

	mfb_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.seg    (seg),
		.take   (take),
		.op     (wop)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign column_bits = bits_q;
	assign done_res = done_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		seg = cmd_seg(op_q, rot_q, xp_q, yp_q, xa_q, ya_q, seg_k_q[1:0]);
		start = (state_q == S_SEG) && (seg_k_q < seg_count(op_q));
		take = (state_q == S_WALK) && wop.active;
		rd_addr = (state_q == S_IDLE) ? x_pos[COL_W-1:0] : wop.col;
		old_word = vld_q[col_q] ? rdata_q : '0;
		wdata = xor_q ? (old_word ^ mask_q) : (old_word | mask_q);
		rd_in_range = (xp_q >= ZERO_C) && (xp_q < COLS_C);
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
		if (state_q == S_WR)
			mem[col_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= 1'b0;
			rot_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_XOR_MODE: xor_q <= cfg_data[0];
				REG_ROTATE:   rot_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_q <= '0;
			seg_k_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (opcode_t'(opcode))
							OP_CLEAR: begin
								vld_q <= '0;
								state_q <= S_RESP;
							end
							OP_READ: state_q <= S_RDC;
							OP_HSPAN, OP_VSPAN, OP_LINE, OP_RECT, OP_FILL: begin
								seg_k_q <= '0;
								state_q <= S_SEG;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_SEG: begin
					if (start) begin
						seg_k_q <= seg_k_q + 3'd1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_WALK: begin
					if (!wop.active)
						state_q <= S_SEG;
					else if (wop.hit)
						state_q <= S_WR;
				end
				S_WR: begin
					vld_q[col_q] <= 1'b1;
					state_q <= S_WALK;
				end
				S_RDC: state_q <= S_RESP;
				S_RESP: begin
					if (!res_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			op_q <= opcode_t'(opcode);
			xp_q <= coord_t'(x_pos);
			yp_q <= coord_t'(y_pos);
			xa_q <= coord_t'(x_arg);
			ya_q <= coord_t'(y_arg);
			bits_q <= '0;
			case (opcode_t'(opcode))
				OP_CLEAR, OP_HSPAN, OP_VSPAN, OP_LINE, OP_RECT, OP_FILL, OP_READ:
					done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
		if (state_q == S_WALK && wop.active && wop.hit) begin
			col_q <= wop.col;
			mask_q <= wop.mask;
		end
		if (state_q == S_RDC)
			bits_q <= (rd_in_range && vld_q[xp_q[COL_W-1:0]]) ? rdata_q : '0;
	end

	`MFB_ASSERT_SAME(a_wr_after_walk, state_q == S_WR, $past(state_q) == S_WALK, "write without walk")
	`MFB_ASSERT_NEXT(a_busy_after_beat, cmd_valid && !cmd_stall, state_q != S_IDLE, "beat not taken")
	`MFB_ASSERT_SAME(a_bits_need_done, res_valid && column_bits != '0, done_res, "bits without done")

endmodule
